@@ src/synth_freq_from_divider_regs_core_macros.svh @@
// Assertion macros shared by the core's RTL.
`ifndef SYNTH_FREQ_FROM_DIVIDER_REGS_CORE_MACROS_SVH
`define SYNTH_FREQ_FROM_DIVIDER_REGS_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication on i_clk, off during reset
`define SFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication on i_clk, off during reset
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFD_ASSERT_NOW(label, ante, cons)
`define SFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/sfd_pkg.sv @@
`default_nettype none

package sfd_pkg;

    // Field widths
    localparam int IMG_W       = 48;
    localparam int XTAL_W      = 32;
    localparam int RFREQ_W     = 38;
    localparam int RFREQ_LO_W  = 32;
    localparam int RFREQ_HI_W  = RFREQ_W - RFREQ_LO_W;
    localparam int FREQ_W      = 32;

    // Divider fields in the register image
    localparam int HS_LSB      = 45;
    localparam int HS_W        = 3;
    localparam int N1_LSB      = 38;
    localparam int N1_W        = 7;
    localparam int HS_OFFSET   = 4;
    localparam int N1_OFFSET   = 1;

    // Divisor is at most 11 * 128 = 1408
    localparam int DIV_W       = 11;
    // Product bits 69:31; a 32x38 product has no bit 70
    localparam int DIVIDEND_W  = 39;
    localparam int PROD_SHIFT  = 31;
    // One restoring-division cell per dividend bit
    localparam int NUM_CELLS   = DIVIDEND_W;

    localparam logic [XTAL_W-1:0] XTAL_RESET = 32'd1917384131;

    // Data moving down the division chain
    typedef struct packed {
        logic [DIV_W-1:0]      rem;
        logic [DIVIDEND_W-1:0] work;
        logic [DIV_W-1:0]      divisor;
    } t_div_req;

endpackage

`default_nettype wire

@@ src/sfd_mul.sv @@
`default_nettype none

// Decodes the dividers and forms the scaled DCO value over two stages.
module sfd_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [sfd_pkg::IMG_W-1:0]     i_image,
    input  wire logic [sfd_pkg::XTAL_W-1:0]    i_xtal,
    output logic                               o_valid,
    output sfd_pkg::t_div_req                  o_req
);

    localparam int PLO_W = sfd_pkg::XTAL_W + sfd_pkg::RFREQ_LO_W;
    localparam int PHI_W = sfd_pkg::XTAL_W + sfd_pkg::RFREQ_HI_W;
    localparam int HS_SUM_W = sfd_pkg::HS_W + 1;
    localparam int N1_SUM_W = sfd_pkg::N1_W + 1;

    logic [sfd_pkg::RFREQ_LO_W-1:0] rfreq_lo;
    logic [sfd_pkg::RFREQ_HI_W-1:0] rfreq_hi;
    logic [HS_SUM_W-1:0]            hs_div;
    logic [N1_SUM_W-1:0]            n1_div;
    logic [HS_SUM_W+N1_SUM_W-1:0]   div_full;
    logic [PLO_W-1:0]               n_plo;
    logic [PHI_W-1:0]               n_phi;

    logic                           r_s1_valid;
    logic [PLO_W-1:0]               r_plo;
    logic [PHI_W-1:0]               r_phi;
    logic [sfd_pkg::DIV_W-1:0]      r_s1_div;

    logic                           r_s2_valid;
    sfd_pkg::t_div_req              r_s2_req;
    sfd_pkg::t_div_req              n_s2_req;

    // Field decode and divisor
    always_comb begin
        rfreq_lo = i_image[sfd_pkg::RFREQ_LO_W-1:0];
        rfreq_hi = i_image[sfd_pkg::RFREQ_W-1:sfd_pkg::RFREQ_LO_W];
        hs_div   = HS_SUM_W'(i_image[sfd_pkg::HS_LSB +: sfd_pkg::HS_W])
                 + HS_SUM_W'(sfd_pkg::HS_OFFSET);
        n1_div   = N1_SUM_W'(i_image[sfd_pkg::N1_LSB +: sfd_pkg::N1_W])
                 + N1_SUM_W'(sfd_pkg::N1_OFFSET);
        div_full = (HS_SUM_W+N1_SUM_W)'(hs_div) * (HS_SUM_W+N1_SUM_W)'(n1_div);
        n_plo    = PLO_W'(i_xtal) * PLO_W'(rfreq_lo);
        n_phi    = PHI_W'(i_xtal) * PHI_W'(rfreq_hi);
    end

    // Stage 1: partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
        if (i_en) begin
            r_plo    <= n_plo;
            r_phi    <= n_phi;
            r_s1_div <= div_full[sfd_pkg::DIV_W-1:0];
        end
    end

    // Stage 2: combine partials into bits 69:31 of the product
    always_comb begin
        n_s2_req.rem     = '0;
        n_s2_req.work    = sfd_pkg::DIVIDEND_W'(r_plo[PLO_W-1:sfd_pkg::PROD_SHIFT])
                         + sfd_pkg::DIVIDEND_W'({r_phi, 1'b0});
        n_s2_req.divisor = r_s1_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (i_en) begin
            r_s2_req <= n_s2_req;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_req   = r_s2_req;

endmodule

`default_nettype wire

@@ src/sfd_div_cell.sv @@
`default_nettype none

// One restoring-division step: shifts in the top dividend bit, trial
// subtracts, and shifts the quotient bit into the bottom of the work word.
module sfd_div_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire sfd_pkg::t_div_req i_req,
    output logic                   o_valid,
    output sfd_pkg::t_div_req      o_req
);

    logic [sfd_pkg::DIV_W:0] trial;
    logic [sfd_pkg::DIV_W:0] diff;
    logic                    q_bit;
    logic                    r_valid;
    sfd_pkg::t_div_req       r_req;
    sfd_pkg::t_div_req       n_req;

    // Trial subtract
    always_comb begin
        trial = {i_req.rem, i_req.work[sfd_pkg::DIVIDEND_W-1]};
        diff  = trial - {1'b0, i_req.divisor};
        q_bit = (trial >= {1'b0, i_req.divisor});
        n_req.rem     = q_bit ? diff[sfd_pkg::DIV_W-1:0] : trial[sfd_pkg::DIV_W-1:0];
        n_req.work    = {i_req.work[sfd_pkg::DIVIDEND_W-2:0], q_bit};
        n_req.divisor = i_req.divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

@@ src/synth_freq_from_divider_regs_core.sv @@
// Output frequency from a divider register image. Each request carries the
// 48-bit image (high-speed divider code, output divider, 38-bit RFREQ); the
// core multiplies RFREQ by the crystal register, takes product bits 69:31 and
// divides by (HS + 4) * (N1 + 1), returning the low 32 quotient bits in 11.21
// MHz. One request is taken every cycle that o_stall is low, then passes two
// multiply stages and a chain of 39 division cells, one quotient bit per
// cell. The last cell is the output register. The whole pipeline holds while
// a result is present and stalled; a result stall with no result present
// holds nothing. Write the crystal register only with no request in flight.
`default_nettype none

`include "synth_freq_from_divider_regs_core_macros.svh"

module synth_freq_from_divider_regs_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [sfd_pkg::XTAL_W-1:0]    i_cfg_wdata,
    // Request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [sfd_pkg::IMG_W-1:0]     i_register_image,
    // Result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sfd_pkg::FREQ_W-1:0]         o_frequency
);

    logic [sfd_pkg::XTAL_W-1:0] r_xtal;
    logic                     pipe_en;
    logic                     cell_valid [0:sfd_pkg::NUM_CELLS];
    sfd_pkg::t_div_req        cell_req   [0:sfd_pkg::NUM_CELLS];

    // Crystal frequency register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal <= sfd_pkg::XTAL_RESET;
        end else if (i_cfg_we) begin
            r_xtal <= i_cfg_wdata;
        end
    end

    // Pipeline moves unless a held result is stalled
    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en;

    sfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_image (i_register_image),
        .i_xtal  (r_xtal),
        .o_valid (cell_valid[0]),
        .o_req   (cell_req[0])
    );

    // Division chain
    for (genvar g = 0; g < sfd_pkg::NUM_CELLS; g++) begin : g_cell
        sfd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (cell_valid[g]),
            .i_req   (cell_req[g]),
            .o_valid (cell_valid[g+1]),
            .o_req   (cell_req[g+1])
        );
    end

    assign o_valid     = cell_valid[sfd_pkg::NUM_CELLS];
    assign o_frequency = cell_req[sfd_pkg::NUM_CELLS].work[sfd_pkg::FREQ_W-1:0];

    // Checks
    `SFD_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, u_mul.r_s1_valid)
    `SFD_ASSERT_NOW(a_divisor_min, cell_valid[0],
        cell_req[0].divisor >= sfd_pkg::DIV_W'(sfd_pkg::HS_OFFSET))
    `SFD_ASSERT_NOW(a_rem_below_div, o_valid,
        cell_req[sfd_pkg::NUM_CELLS].rem < cell_req[sfd_pkg::NUM_CELLS].divisor)

endmodule

`default_nettype wire
